// ===== sv/sss_pkg.sv =====
// Shared package for the seven-segment scan driver with flashing.
// Holds payload types, request and register codes, and the BCD decode table.
// No dependencies.
package sss_pkg;

    // Store geometry.
    localparam int MAX_DIGITS = 8;
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] DOT_BIT = 8'h80;

    // Request codes.
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_TOGGLE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LAST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [POS_W-1:0] digit_pos;
        logic [3:0]       bcd_value;
        logic             start_new;
        logic [POS_W-1:0] range_from;
        logic [POS_W-1:0] range_to;
    } t_req;

    typedef struct packed {
        logic [7:0]       segment_bits;
        logic [POS_W-1:0] digit_select;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Configuration state seen by the engine.
    typedef struct packed {
        logic [CNT_W-1:0]    eff_count;
        logic [POS_W-1:0]    flash_first;
        logic [POS_W-1:0]    flash_last;
        logic [PERIOD_W-1:0] flash_period;
        logic                flash_clear;
    } t_cfg;

    // Segments a..g in bits 0..6; values above nine are blank.
    function automatic logic [7:0] seg_decode(input logic [3:0] bcd);
        logic [7:0] seg;
        case (bcd)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== sv/sss_if.sv =====
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on sss_pkg for the payload types.
interface sss_req_if;
    import sss_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sss_res_if;
    import sss_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sss_cfg_if;
    import sss_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sss_cfg.sv =====
// Configuration register file for the scan driver.
// Depends on sss_pkg and the sss_cfg_if interface.
module sss_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sss_cfg_if.sink        i_cfg,
    output sss_pkg::t_cfg  o_cfg
);
    import sss_pkg::*;

    logic [3:0]          r_digit_count;
    logic [POS_W-1:0]    r_flash_first;
    logic [POS_W-1:0]    r_flash_last;
    logic [PERIOD_W-1:0] r_flash_period;
    logic [CNT_W-1:0]    eff_count;
    logic                wr;

    // Writes are taken whenever the block is out of reset.
    assign i_cfg.ready = i_rst_n;
    assign wr          = i_cfg.valid && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count  <= 4'(MAX_DIGITS);
            r_flash_first  <= '0;
            r_flash_last   <= '0;
            r_flash_period <= '0;
        end else if (wr) begin
            case (i_cfg.data.index)
                CFG_DIGIT_COUNT:  r_digit_count  <= i_cfg.data.data[3:0];
                CFG_FLASH_FIRST:  r_flash_first  <= i_cfg.data.data[POS_W-1:0];
                CFG_FLASH_LAST:   r_flash_last   <= i_cfg.data.data[POS_W-1:0];
                CFG_FLASH_PERIOD: r_flash_period <= i_cfg.data.data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // A count of zero acts as one; counts above the store depth saturate.
    always_comb begin
        if (r_digit_count == 4'd0) begin
            eff_count = CNT_W'(1);
        end else if (r_digit_count > 4'(MAX_DIGITS)) begin
            eff_count = CNT_W'(MAX_DIGITS);
        end else begin
            eff_count = r_digit_count[CNT_W-1:0];
        end
    end

    assign o_cfg.eff_count    = eff_count;
    assign o_cfg.flash_first  = r_flash_first;
    assign o_cfg.flash_last   = r_flash_last;
    assign o_cfg.flash_period = r_flash_period;
    // Writing the period restarts the flash cycle.
    assign o_cfg.flash_clear  = wr && (i_cfg.data.index == CFG_FLASH_PERIOD);

endmodule

// ===== sv/sss_engine.sv =====
// Digit store, scan position and flash counter, with the result logic of one item.
// Depends on sss_pkg.
module sss_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  sss_pkg::t_req i_req,
    input  sss_pkg::t_cfg i_cfg,
    output sss_pkg::t_res o_res
);
    import sss_pkg::*;

    logic [7:0]          r_store [MAX_DIGITS];
    logic [7:0]          n_store [MAX_DIGITS];
    logic [POS_W-1:0]    r_scan;
    logic [POS_W-1:0]    n_scan;
    logic [PERIOD_W-1:0] r_flash;
    logic [PERIOD_W-1:0] n_flash;
    logic [CNT_W-1:0]    scan_sum;
    logic                wrap;
    logic [PERIOD_W-1:0] flash_inc;
    logic                blank;
    logic [7:0]          new_seg;
    logic                is_write;
    logic                is_toggle;
    logic                is_tick;

    assign is_write  = i_step && (i_req.req_type == REQ_WRITE);
    assign is_toggle = i_step && (i_req.req_type == REQ_TOGGLE);
    assign is_tick   = i_step && (i_req.req_type == REQ_TICK);
    assign new_seg   = seg_decode(i_req.bcd_value);

    // Store update: optional clear then write, or a dot toggle over a range.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            n_store[i] = r_store[i];
            if (is_write) begin
                if (i_req.start_new) begin
                    n_store[i] = '0;
                end
                if ((i_req.digit_pos == POS_W'(i)) &&
                    ({1'b0, i_req.digit_pos} < i_cfg.eff_count)) begin
                    n_store[i] = new_seg;
                end
            end
            if (is_toggle && (i_req.range_from <= POS_W'(i)) &&
                (POS_W'(i) <= i_req.range_to)) begin
                n_store[i] = r_store[i] ^ DOT_BIT;
            end
        end
    end

    // Scan advance with wrap at the effective digit count.
    assign scan_sum  = CNT_W'(r_scan) + CNT_W'(1);
    assign wrap      = scan_sum >= i_cfg.eff_count;
    assign flash_inc = r_flash + PERIOD_W'(1);

    always_comb begin
        n_scan  = r_scan;
        n_flash = r_flash;
        if (is_tick) begin
            n_scan = wrap ? '0 : scan_sum[POS_W-1:0];
            if (wrap) begin
                n_flash = (flash_inc >= i_cfg.flash_period) ? '0 : flash_inc;
            end
        end
        if (i_cfg.flash_clear) begin
            n_flash = '0;
        end
    end

    // Result of a tick: the new digit, blanked in the second half of the flash cycle.
    assign blank = (i_cfg.flash_period != '0) &&
                   (n_flash >= (i_cfg.flash_period >> 1)) &&
                   (n_scan >= i_cfg.flash_first) && (n_scan <= i_cfg.flash_last);

    assign o_res.segment_bits = blank ? 8'h00 : r_store[n_scan];
    assign o_res.digit_select = n_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= '0;
            end
            r_scan  <= POS_W'(MAX_DIGITS - 1);
            r_flash <= '0;
        end else begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= n_store[i];
            end
            r_scan  <= n_scan;
            r_flash <= n_flash;
        end
    end

endmodule

// ===== sv/seven_segment_scan_with_flash_top.sv =====
// Top level of the multiplexed seven-segment scan driver with flashing.
// Depends on sss_pkg, the channel interfaces, sss_cfg and sss_engine.
//
//  Channel  Dir  Carries                                  Transfer
//  i_req    in   req_type, digit_pos, bcd_value,          valid & ready
//                start_new, range_from, range_to
//  o_res    out  segment_bits, digit_select (ticks only)  valid & ready
//  i_cfg    in   register index, write data               valid & ready
//
// A request is registered on transfer and processed from the input register; a
// tick's result goes into the output register, which drives o_res.
// One request per cycle is sustained while no result stalls; the input and output
// registers are the only pipeline. A stalled result holds the output register, and
// the input register then holds the next tick until the result goes out.
// Reset is synchronous: all digits blank, scan at the last position.
module seven_segment_scan_with_flash_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sss_req_if.sink   i_req,
    sss_res_if.source o_res,
    sss_cfg_if.sink   i_cfg
);
    import sss_pkg::*;

    logic  r_in_valid;
    t_req  r_in;
    logic  r_out_valid;
    t_res  r_out;
    logic  in_is_tick;
    logic  step;
    t_cfg  cfg;
    t_res  res;

    sss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sss_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // The held request moves on unless it is a tick facing a full output register whose result is stalled.
    assign in_is_tick  = r_in.req_type == REQ_TICK;
    assign step        = r_in_valid && (!in_is_tick || !r_out_valid || o_res.ready);
    assign i_req.ready = i_rst_n && (!r_in_valid || step);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && in_is_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && in_is_tick) begin
            r_out <= res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// ===== sv/sss_checker.sv =====
// Port-level checks for the seven-segment scan driver, bound to its top level.
// Depends on sss_pkg and seven_segment_scan_with_flash_top.
module sss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input sss_pkg::t_req i_req_data,
    input logic          i_res_valid,
    input logic          i_res_ready,
    input sss_pkg::t_res i_res_data
);
    import sss_pkg::*;

    logic req_xfer;
    assign req_xfer = i_req_valid && i_req_ready;

    // A stalled result keeps its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // An output that starts fresh comes from a tick taken earlier on the request channel.
    a_rise_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |->
            $past(req_xfer && (i_req_data.req_type == REQ_TICK), 2))
        else $error("result appeared without a tick");

    // No request is taken during reset.
    a_no_take_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> !i_req_ready)
        else $error("request taken during reset");

endmodule

bind seven_segment_scan_with_flash_top sss_checker u_sss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_data  (i_req.data),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

// ===== test/tb_seven_segment_scan_with_flash_top.sv =====
// Self-checking testbench for the seven-segment scan driver with flashing.
// A scoreboard class predicts every scan output from accepted requests and register writes.
// Depends on sss_pkg, the channel interfaces in sss_if.sv and seven_segment_scan_with_flash_top.
module tb_seven_segment_scan_with_flash_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_PHASE      = 1;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_LIMIT    = 10;

    // The request type the block leaves unused.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Receiver stall patterns.
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_mode;

    // Tracks the digit store, scan and flash state, and the scan outputs still owed.
    class scan_scoreboard;
        logic [7:0]          digits[MAX_DIGITS];
        logic [POS_W-1:0]    scan_pos;
        logic [PERIOD_W-1:0] flash_cnt;
        logic [CNT_W-1:0]    digit_count;
        logic [POS_W-1:0]    flash_first;
        logic [POS_W-1:0]    flash_last;
        logic [PERIOD_W-1:0] flash_period;
        logic [7:0]          glyphs[10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                            8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
        t_res                expected_scan[$];
        int                  errors;

        function new();
            foreach (digits[i]) digits[i] = '0;
            digit_count  = CNT_W'(MAX_DIGITS);
            flash_first  = '0;
            flash_last   = '0;
            flash_period = '0;
            flash_cnt    = '0;
            errors       = 0;
            scan_pos     = POS_W'(active_digits() - 1);
        endfunction

        // A count of zero scans one digit; large counts are clipped to the store.
        function logic [CNT_W-1:0] active_digits();
            if (digit_count == 0) return 1;
            if (digit_count > MAX_DIGITS) return CNT_W'(MAX_DIGITS);
            return digit_count;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIGIT_COUNT: begin
                    digit_count = data[CNT_W-1:0];
                end
                CFG_FLASH_FIRST: begin
                    flash_first = data[POS_W-1:0];
                end
                CFG_FLASH_LAST: begin
                    flash_last = data[POS_W-1:0];
                end
                CFG_FLASH_PERIOD: begin
                    flash_period = data[PERIOD_W-1:0];
                    flash_cnt    = '0;
                end
                default: begin
                end
            endcase
        endfunction

        // Apply one accepted request; a refresh tick queues the scan output it causes.
        function void note_request(t_req r);
            logic [CNT_W-1:0] count;
            logic [CNT_W-1:0] next;
            logic [7:0]       seg;
            t_res             res;
            count = active_digits();
            case (r.req_type)
                REQ_WRITE: begin
                    if (r.start_new) begin
                        foreach (digits[i]) digits[i] = '0;
                    end
                    if (r.digit_pos < count) begin
                        digits[r.digit_pos] = (r.bcd_value <= 9) ? glyphs[r.bcd_value] : 8'h00;
                    end
                end
                REQ_TOGGLE: begin
                    for (int i = r.range_from; i <= r.range_to; i++) begin
                        digits[i] = digits[i] ^ DOT_BIT;
                    end
                end
                REQ_TICK: begin
                    next = CNT_W'(scan_pos) + 1'b1;
                    if (next >= count) next = '0;
                    scan_pos = next[POS_W-1:0];
                    // The flash counter advances once per scan round.
                    if (next == 0) begin
                        flash_cnt = flash_cnt + 1'b1;
                        if (flash_cnt >= flash_period) flash_cnt = '0;
                    end
                    seg = digits[scan_pos];
                    if (flash_period != 0 && flash_cnt >= (flash_period >> 1) &&
                        scan_pos >= flash_first && scan_pos <= flash_last) begin
                        seg = 8'h00;
                    end
                    res.segment_bits = seg;
                    res.digit_select = scan_pos;
                    expected_scan.push_back(res);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_scan_out(t_res got);
            t_res exp;
            if (expected_scan.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("ERROR: unexpected scan output seg=%02h sel=%0d",
                             got.segment_bits, got.digit_select);
                end
                return;
            end
            exp = expected_scan.pop_front();
            if (got.segment_bits !== exp.segment_bits || got.digit_select !== exp.digit_select) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("ERROR: scan output seg=%02h sel=%0d, expected seg=%02h sel=%0d",
                             got.segment_bits, got.digit_select,
                             exp.segment_bits, exp.digit_select);
                end
            end
        endfunction

        function int pending();
            return expected_scan.size();
        endfunction

        // Outputs still owed at the end count as failures.
        function int close();
            if (expected_scan.size() != 0) begin
                $display("ERROR: %0d scan outputs never arrived", expected_scan.size());
                errors += expected_scan.size();
            end
            return errors;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    bit   long_hold_req = 1'b0;

    scan_scoreboard book;

    sss_req_if req_ch ();
    sss_res_if res_ch ();
    sss_cfg_if cfg_ch ();

    seven_segment_scan_with_flash_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Check every result transfer against the oldest expected scan output.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            book.check_scan_out(res_ch.data);
        end
    end

    // Receiver: changes its stall pattern now and then, and honors one long hold-off.
    initial begin
        t_rx_mode mode;
        int       span;
        int       beat;
        int       hold_left;
        res_ch.ready = 1'b0;
        beat      = 0;
        hold_left = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge i_clk);
                beat++;
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    hold_left = LONG_HOLD - 1;
                    res_ch.ready <= 1'b0;
                end else if (hold_left > 0) begin
                    hold_left--;
                    res_ch.ready <= 1'b0;
                end else begin
                    case (mode)
                        RX_OPEN:   res_ch.ready <= 1'b1;
                        RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                        default:   res_ch.ready <= (beat % 3 != 0);
                    endcase
                end
            end
        end
    end

    function automatic t_req request_of(logic [1:0] kind, logic [POS_W-1:0] pos,
                                        logic [3:0] bcd, logic start,
                                        logic [POS_W-1:0] from, logic [POS_W-1:0] to);
        t_req r;
        r.req_type   = kind;
        r.digit_pos  = pos;
        r.bcd_value  = bcd;
        r.start_new  = start;
        r.range_from = from;
        r.range_to   = to;
        return r;
    endfunction

    // Mostly ticks and writes, some dot toggles, a few unused request codes.
    function automatic t_req rand_request();
        t_req        r;
        int unsigned pick;
        r = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 45) r.req_type = REQ_TICK;
        else if (pick < 75) r.req_type = REQ_WRITE;
        else if (pick < 95) r.req_type = REQ_TOGGLE;
        else r.req_type = REQ_UNUSED;
        r.start_new = ($urandom_range(0, 11) == 0);
        return r;
    endfunction

    // Offer one request from a falling edge and return at the falling edge after its transfer.
    task automatic push_req(input t_req r);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        book.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_cfg_wr wr;
        wr.index = idx;
        wr.data  = data;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= wr;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        book.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Narrow registers sometimes get junk in their unused upper bits.
    function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned value, int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if ($urandom_range(0, 1) == 1) data = data | (CFG_DATA_W'($urandom()) << width);
        return data;
    endfunction

    task automatic configure(input int unsigned count, input int unsigned first,
                             input int unsigned last, input int unsigned period,
                             input logic [3:0] mask);
        if (mask[0]) write_reg(CFG_DIGIT_COUNT, with_junk(count, CNT_W));
        if (mask[1]) write_reg(CFG_FLASH_FIRST, with_junk(first, POS_W));
        if (mask[2]) write_reg(CFG_FLASH_LAST, with_junk(last, POS_W));
        if (mask[3]) write_reg(CFG_FLASH_PERIOD, CFG_DATA_W'(period));
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every scan output is in and writes still in flight have landed.
    task automatic wait_idle();
        while (book.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random requests in bursts; ignored request codes do not count toward n.
    task automatic run_random(input int n, input bit no_gaps);
        t_req r;
        int   sent;
        int   burst;
        int   gap;
        sent  = 0;
        burst = $urandom_range(1, 20);
        while (sent < n) begin
            r = rand_request();
            push_req(r);
            if (r.req_type != REQ_UNUSED) sent++;
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if (no_gaps) gap = 0;
                else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 20);
                else gap = $urandom_range(0, 4);
                if (gap > 0) begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
        req_ch.valid <= 1'b0;
    endtask

    // Stimulus: directed checks on the reset settings, then random phases over many settings.
    initial begin
        int unsigned ph_count[8]  = '{8, 1, 0, 15, 3, 5, 8, 4};
        int unsigned ph_first[8]  = '{0, 0, 0, 0, 1, 6, 7, 0};
        int unsigned ph_last[8]   = '{0, 0, 0, 7, 2, 2, 7, 7};
        int unsigned ph_period[8] = '{0, 2, 1, 4, 3, 2, 65535, 6};
        t_req        directed[$];
        int unsigned period;

        book = new();
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the store with every decimal digit, then blanks for codes above nine.
        directed.push_back(request_of(REQ_WRITE, 0, 0, 1'b1, 0, 0));
        for (int d = 1; d <= 7; d++) begin
            directed.push_back(request_of(REQ_WRITE, POS_W'(d), 4'(d), 1'b0, 0, 0));
        end
        directed.push_back(request_of(REQ_WRITE, 0, 8, 1'b0, 0, 0));
        directed.push_back(request_of(REQ_WRITE, 1, 9, 1'b0, 0, 0));
        directed.push_back(request_of(REQ_WRITE, 2, 10, 1'b0, 0, 0));
        directed.push_back(request_of(REQ_WRITE, 3, 15, 1'b0, 0, 0));
        // Dots over the full range, an inverted range that does nothing, and one position.
        directed.push_back(request_of(REQ_TOGGLE, 0, 0, 1'b0, 0, 7));
        directed.push_back(request_of(REQ_TOGGLE, 0, 0, 1'b0, 5, 2));
        directed.push_back(request_of(REQ_TOGGLE, 0, 0, 1'b0, 3, 3));
        // The unused request code with every field at its top.
        directed.push_back(request_of(REQ_UNUSED, 7, 15, 1'b1, 7, 7));
        // A full scan round starting with the wrap from the last position.
        for (int t = 0; t < 8; t++) directed.push_back(request_of(REQ_TICK, 0, 0, 1'b0, 0, 0));
        // A clearing write at the top position, then one more tick.
        directed.push_back(request_of(REQ_WRITE, 7, 9, 1'b1, 0, 0));
        directed.push_back(request_of(REQ_TICK, 0, 0, 1'b0, 0, 0));
        foreach (directed[i]) push_req(directed[i]);
        req_ch.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p < 8) begin
                configure(ph_count[p], ph_first[p], ph_last[p], ph_period[p], 4'b1111);
            end else begin
                period = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 9);
                configure($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
                          period, 4'($urandom_range(1, 15)));
            end
            if (p == HOLD_PHASE) long_hold_req = 1'b1;
            run_random(ITEMS_PER_PHASE, p == HOLD_PHASE);
        end

        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.close() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
